@@ hw/rtl/pending_read_match_queue_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the pending read match queue
// Implication and next-cycle implication checks, gated by the active-low reset.
// ---------------------------------------------------------------------------
`ifndef PENDING_READ_MATCH_QUEUE_UNIT_DEFINES_SVH
`define PENDING_READ_MATCH_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication
`define PRMQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prmq assertion failed");

// next-cycle implication
`define PRMQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prmq assertion failed");

`endif

@@ hw/rtl/prmq_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pending read match queue package
// Field widths, codes and transfer types shared by the queue modules.
// ---------------------------------------------------------------------------
package prmq_pkg;

    localparam int DEFAULT_SLOTS = 64;
    localparam int TAG_W         = 8;
    localparam int ADDR_W        = 64;
    localparam int LEN_W         = 12;
    localparam int OCC_W         = 6;

    // item function codes
    typedef enum logic [1:0] {
        FUNC_ENQ    = 2'd0,
        FUNC_REPLY  = 2'd1,
        FUNC_CANCEL = 2'd2
    } t_func;

    // result kinds
    typedef enum logic [1:0] {
        KIND_ENQ    = 2'd0,
        KIND_FULL   = 2'd1,
        KIND_ANSWER = 2'd2,
        KIND_FLUSH  = 2'd3
    } t_kind;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_FLUSH
    } t_state;

    // input item
    typedef struct packed {
        t_func              func;
        logic [TAG_W-1:0]   tag;
        logic [ADDR_W-1:0]  address;
        logic [LEN_W-1:0]   request_length;
        logic [LEN_W-1:0]   reply_length;
    } t_req;

    // result item
    typedef struct packed {
        logic [TAG_W-1:0]   result_tag;
        t_kind              kind;
        logic [LEN_W-1:0]   delivered_length;
        logic [OCC_W-1:0]   occupancy;
        logic               last;
    } t_rsp;

    // one pending request held in a cell
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [TAG_W-1:0]   tag;
        logic [LEN_W-1:0]   len;
    } t_entry;

    // per-cell control
    typedef struct packed {
        logic load;   // capture the new request
        logic shift;  // take the entry of the next younger cell
        logic cmp;    // cell is live and a reply address is offered
    } t_cell_ctl;

endpackage

@@ hw/rtl/prmq_cell.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pending read match queue cell
// Holds one pending request, shifts toward the oldest end and compares a
// reply address against its stored address.
// ---------------------------------------------------------------------------
module prmq_cell (
    input  logic                          i_clk,
    input  prmq_pkg::t_cell_ctl           i_ctl,
    input  prmq_pkg::t_entry              i_new,
    input  prmq_pkg::t_entry              i_up,
    input  logic [prmq_pkg::ADDR_W-1:0]   i_addr,
    output prmq_pkg::t_entry              o_entry,
    output logic                          o_hit
);

    prmq_pkg::t_entry r_entry;
    logic             r_hit;

    // entry storage: load from the request or take the younger neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_new;
        end else if (i_ctl.shift) begin
            r_entry <= i_up;
        end
    end

    // address compare, registered for the next cycle
    always_ff @(posedge i_clk) begin
        r_hit <= i_ctl.cmp && (i_addr == r_entry.addr);
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

@@ hw/rtl/prmq_pick.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pending read match queue picker
// Finds the oldest hitting cell, selects its tag and length and marks the
// cells that close the gap left by its removal.
// ---------------------------------------------------------------------------
module prmq_pick #(
    parameter int N = prmq_pkg::DEFAULT_SLOTS - 1
) (
    input  logic [N-1:0]                 i_hit,
    input  prmq_pkg::t_entry             i_entry [N],
    output logic                         o_any,
    output logic [N-1:0]                 o_shift,
    output logic [prmq_pkg::TAG_W-1:0]   o_tag,
    output logic [prmq_pkg::LEN_W-1:0]   o_len
);

    logic [N-1:0] w_first;

    // lowest set bit is the oldest match
    assign w_first = i_hit & (~i_hit + N'(1));
    assign o_any   = |i_hit;
    // cells at and above the match take from their younger neighbor
    assign o_shift = ~(w_first - N'(1));

    // one-hot select of the matched entry
    always_comb begin
        o_tag = '0;
        o_len = '0;
        for (int k = 0; k < N; k++) begin
            o_tag = o_tag | (i_entry[k].tag & {prmq_pkg::TAG_W{w_first[k]}});
            o_len = o_len | (i_entry[k].len & {prmq_pkg::LEN_W{w_first[k]}});
        end
    end

endmodule

@@ hw/rtl/pending_read_match_queue_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pending read match queue unit
// Tracks outstanding bus reads in a row of compacting cells, matches replies
// by address and flushes pending requests on cancel or empty reply.
// ---------------------------------------------------------------------------
// Items are taken while busy is low. An enqueue's result strobes in the next
// cycle; busy stays low, so enqueues can follow back to back. A reply raises
// busy for the match state: every cell compares the address at the accept
// edge, the oldest hit is removed in the following cycle, and its answer
// strobes in the cycle after that. A flush (cancel, or an empty reply with no
// match) strobes one result per cycle, oldest first, and keeps busy high until
// every pending request has been flushed, entering the flush state from the
// accept for cancel or from the match state for a reply. Results carry a last
// bit and cannot be held off by the receiver.
// ---------------------------------------------------------------------------
`include "pending_read_match_queue_unit_defines.svh"

module pending_read_match_queue_unit #(
    parameter int QUEUE_SLOTS = prmq_pkg::DEFAULT_SLOTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  prmq_pkg::t_req    i_req,
    output logic              o_strobe,
    output prmq_pkg::t_rsp    o_result
);

    localparam int N  = QUEUE_SLOTS - 1;
    localparam int CW = $clog2(QUEUE_SLOTS);

    prmq_pkg::t_state             r_state, n_state;
    logic [CW-1:0]                r_count, n_count;
    logic [prmq_pkg::LEN_W-1:0]   r_rplen, n_rplen;
    logic                         r_strobe, n_strobe;
    prmq_pkg::t_rsp               r_result, n_result;

    logic                         w_accept;
    logic                         w_load;
    logic                         w_cmp;
    logic                         w_shift_all;
    logic                         w_shift_match;
    prmq_pkg::t_entry             w_new;
    prmq_pkg::t_entry             w_entry [N];
    prmq_pkg::t_cell_ctl          w_ctl [N];
    logic [N-1:0]                 w_hit;
    logic                         w_any;
    logic [N-1:0]                 w_shift;
    logic [prmq_pkg::TAG_W-1:0]   w_tag;
    logic [prmq_pkg::LEN_W-1:0]   w_len;

    assign busy     = (r_state != prmq_pkg::ST_IDLE);
    assign w_accept = start && !busy;

    assign w_new.addr = i_req.address;
    assign w_new.tag  = i_req.tag;
    assign w_new.len  = i_req.request_length;

    // cell row, oldest entry in cell 0
    for (genvar k = 0; k < N; k++) begin : g_cell
        assign w_ctl[k].load  = w_load && (r_count == CW'(k));
        assign w_ctl[k].shift = w_shift_all || (w_shift_match && w_shift[k]);
        assign w_ctl[k].cmp   = w_cmp && (CW'(k) < r_count);

        if (k == N - 1) begin : g_end
            prmq_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl[k]),
                .i_new   (w_new),
                .i_up    (w_entry[k]),
                .i_addr  (i_req.address),
                .o_entry (w_entry[k]),
                .o_hit   (w_hit[k])
            );
        end else begin : g_mid
            prmq_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl[k]),
                .i_new   (w_new),
                .i_up    (w_entry[k+1]),
                .i_addr  (i_req.address),
                .o_entry (w_entry[k]),
                .o_hit   (w_hit[k])
            );
        end
    end

    // oldest match selection
    prmq_pick #(.N(N)) u_pick (
        .i_hit   (w_hit),
        .i_entry (w_entry),
        .o_any   (w_any),
        .o_shift (w_shift),
        .o_tag   (w_tag),
        .o_len   (w_len)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            prmq_pkg::ST_IDLE: begin
                if (w_accept && (i_req.func == prmq_pkg::FUNC_REPLY)) begin
                    n_state = prmq_pkg::ST_MATCH;
                end else if (w_accept && (i_req.func == prmq_pkg::FUNC_CANCEL)
                             && (r_count != '0)) begin
                    n_state = prmq_pkg::ST_FLUSH;
                end
            end
            prmq_pkg::ST_MATCH: begin
                if (!w_any && (r_rplen == '0) && (r_count != '0)) begin
                    n_state = prmq_pkg::ST_FLUSH;
                end else begin
                    n_state = prmq_pkg::ST_IDLE;
                end
            end
            prmq_pkg::ST_FLUSH: begin
                if (r_count == CW'(1)) begin
                    n_state = prmq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = prmq_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath control and result
    always_comb begin
        n_count       = r_count;
        n_rplen       = r_rplen;
        n_strobe      = 1'b0;
        n_result      = r_result;
        w_load        = 1'b0;
        w_cmp         = 1'b0;
        w_shift_all   = 1'b0;
        w_shift_match = 1'b0;
        case (r_state)
            prmq_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (i_req.func)
                        prmq_pkg::FUNC_ENQ: begin
                            n_strobe                  = 1'b1;
                            n_result.result_tag       = i_req.tag;
                            n_result.delivered_length = '0;
                            n_result.last             = 1'b1;
                            if (r_count == CW'(N)) begin
                                n_result.kind      = prmq_pkg::KIND_FULL;
                                n_result.occupancy = prmq_pkg::OCC_W'(r_count);
                            end else begin
                                w_load             = 1'b1;
                                n_count            = r_count + CW'(1);
                                n_result.kind      = prmq_pkg::KIND_ENQ;
                                n_result.occupancy = prmq_pkg::OCC_W'(n_count);
                            end
                        end
                        prmq_pkg::FUNC_REPLY: begin
                            w_cmp   = 1'b1;
                            n_rplen = i_req.reply_length;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            prmq_pkg::ST_MATCH: begin
                if (w_any) begin
                    w_shift_match             = 1'b1;
                    n_count                   = r_count - CW'(1);
                    n_strobe                  = 1'b1;
                    n_result.result_tag       = w_tag;
                    n_result.kind             = prmq_pkg::KIND_ANSWER;
                    n_result.delivered_length = (r_rplen < w_len) ? r_rplen : w_len;
                    n_result.occupancy        = prmq_pkg::OCC_W'(n_count);
                    n_result.last             = 1'b1;
                end
            end
            prmq_pkg::ST_FLUSH: begin
                w_shift_all               = 1'b1;
                n_count                   = r_count - CW'(1);
                n_strobe                  = 1'b1;
                n_result.result_tag       = w_entry[0].tag;
                n_result.kind             = prmq_pkg::KIND_FLUSH;
                n_result.delivered_length = '0;
                n_result.occupancy        = prmq_pkg::OCC_W'(n_count);
                n_result.last             = (r_count == CW'(1));
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= prmq_pkg::ST_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rplen  <= n_rplen;
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // checks
    `PRMQ_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(N))
    `PRMQ_ASSERT_NXT(a_flush_emits, i_clk, i_rst_n, r_state == prmq_pkg::ST_FLUSH, o_strobe && (o_result.kind == prmq_pkg::KIND_FLUSH))
    `PRMQ_ASSERT_NXT(a_match_drops_one, i_clk, i_rst_n, (r_state == prmq_pkg::ST_MATCH) && w_any, r_count == $past(r_count) - CW'(1))
    `PRMQ_ASSERT_IMP(a_flush_end_idle, i_clk, i_rst_n, o_strobe && o_result.last && (o_result.kind == prmq_pkg::KIND_FLUSH), (r_state == prmq_pkg::ST_IDLE) && (r_count == '0))

endmodule

@@ verif/pending_read_match_queue_unit_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pending read match queue unit testbench
// Drives enqueue, reply, cancel and unused items through the command
// handshake. A scoreboard keeps its own ordered list of pending reads,
// predicts every result an accepted item causes, and compares each strobed
// result field by field. Bursty stimulus, one fill past the full mark, and
// pauses that wait for all results to come back.
// ---------------------------------------------------------------------------

import prmq_pkg::*;

// Pending-read predictor plus expected-result store
class read_tracker_scoreboard;

    t_entry pending_reads[$];     // oldest first
    t_rsp   expected_results[$];
    int     failures;
    int     shown;

    function new();
        failures = 0;
        shown    = 0;
    endfunction

    // occupancy is taken after the list has been updated
    function void push_expected(logic [TAG_W-1:0] tag, t_kind kind,
                                logic [LEN_W-1:0] len, logic last);
        t_rsp r;
        r.result_tag       = tag;
        r.kind             = kind;
        r.delivered_length = len;
        r.occupancy        = OCC_W'(pending_reads.size());
        r.last             = last;
        expected_results.push_back(r);
    endfunction

    // every pending read answered with zero length, oldest first
    function void flush_pending();
        t_entry e;
        while (pending_reads.size() != 0) begin
            e = pending_reads.pop_front();
            push_expected(e.tag, KIND_FLUSH, '0, pending_reads.size() == 0);
        end
    endfunction

    function void accept_item(t_req item);
        int     hit;
        t_entry e;
        hit = -1;
        case (item.func)
            FUNC_ENQ: begin
                if (pending_reads.size() == DEFAULT_SLOTS - 1) begin
                    push_expected(item.tag, KIND_FULL, '0, 1'b1);
                end else begin
                    e.addr = item.address;
                    e.tag  = item.tag;
                    e.len  = item.request_length;
                    pending_reads.push_back(e);
                    push_expected(item.tag, KIND_ENQ, '0, 1'b1);
                end
            end
            FUNC_REPLY: begin
                // oldest entry with an equal address wins
                foreach (pending_reads[i]) begin
                    if (hit < 0 && pending_reads[i].addr == item.address) hit = i;
                end
                if (hit >= 0) begin
                    e = pending_reads[hit];
                    pending_reads.delete(hit);
                    push_expected(e.tag, KIND_ANSWER,
                                  (item.reply_length < e.len) ? item.reply_length : e.len,
                                  1'b1);
                end else if (item.reply_length == '0) begin
                    flush_pending();
                end
            end
            FUNC_CANCEL: flush_pending();
            default: ;  // unused code, no effect
        endcase
    endfunction

    function void check_result(t_rsp got);
        t_rsp want;
        if (expected_results.size() == 0) begin
            failures++;
            if (shown < 10) begin
                shown++;
                $display("unexpected result: tag %0d kind %0d len %0d occ %0d last %0d",
                         got.result_tag, got.kind, got.delivered_length,
                         got.occupancy, got.last);
            end
            return;
        end
        want = expected_results.pop_front();
        if (got.result_tag !== want.result_tag || got.kind !== want.kind ||
            got.delivered_length !== want.delivered_length ||
            got.occupancy !== want.occupancy || got.last !== want.last) begin
            failures++;
            if (shown < 10) begin
                shown++;
                $display("mismatch: expected tag %0d kind %0d len %0d occ %0d last %0d",
                         want.result_tag, want.kind, want.delivered_length,
                         want.occupancy, want.last);
                $display("          actual   tag %0d kind %0d len %0d occ %0d last %0d",
                         got.result_tag, got.kind, got.delivered_length,
                         got.occupancy, got.last);
            end
        end
    endfunction

    function void flag_leftovers();
        if (expected_results.size() != 0) begin
            failures += expected_results.size();
            $display("%0d expected results never arrived", expected_results.size());
        end
    endfunction

endclass

module pending_read_match_queue_unit_test;

    logic   i_clk   = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start   = 1'b0;
    logic   busy;
    t_req   i_req   = '0;
    logic   o_strobe;
    t_rsp   o_result;

    read_tracker_scoreboard tracker;
    logic [ADDR_W-1:0]      addr_pool[$];   // recently enqueued addresses
    int                     burst_left;
    int                     counted;
    t_req                   item;

    pending_read_match_queue_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // transfer monitor: results first, then the newly accepted item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) tracker.check_result(o_result);
            if (start && !busy) tracker.accept_item(i_req);
        end
    end

    function automatic t_req make_item(t_func f, logic [TAG_W-1:0] tag,
                                       logic [ADDR_W-1:0] addr,
                                       logic [LEN_W-1:0] rq, logic [LEN_W-1:0] rp);
        t_req r;
        r.func           = f;
        r.tag            = tag;
        r.address        = addr;
        r.request_length = rq;
        r.reply_length   = rp;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ADDR_W-1:0] pool_addr();
        if (addr_pool.size() == 0) return rand_addr();
        return addr_pool[$urandom_range(0, addr_pool.size() - 1)];
    endfunction

    // mostly legal lengths, some above 2048, some extremes
    function automatic logic [LEN_W-1:0] rand_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85) return LEN_W'($urandom_range(0, 2048));
        if (roll < 95) return LEN_W'($urandom_range(2049, 4095));
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return LEN_W'(2048);
            default: return '1;
        endcase
    endfunction

    function automatic t_req next_random_item();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return make_item(FUNC_ENQ, TAG_W'($urandom),
                             ($urandom_range(0, 3) == 0) ? pool_addr() : rand_addr(),
                             rand_len(), LEN_W'($urandom));
        if (roll < 80)
            return make_item(FUNC_REPLY, TAG_W'($urandom), pool_addr(),
                             LEN_W'($urandom), rand_len());
        if (roll < 88)
            return make_item(FUNC_REPLY, TAG_W'($urandom), rand_addr(),
                             LEN_W'($urandom), LEN_W'($urandom_range(1, 4095)));
        if (roll < 93)
            return make_item(FUNC_REPLY, TAG_W'($urandom),
                             $urandom_range(0, 1) ? pool_addr() : rand_addr(),
                             LEN_W'($urandom), '0);
        if (roll < 97)
            return make_item(FUNC_CANCEL, TAG_W'($urandom), rand_addr(),
                             LEN_W'($urandom), LEN_W'($urandom));
        return make_item(t_func'(2'd3), TAG_W'($urandom), rand_addr(),
                         LEN_W'($urandom), LEN_W'($urandom));
    endfunction

    // only called with n >= 1, so start never gets two updates in one step
    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // wait until every predicted result has come back, then let the block settle
    task automatic drain_results(input int max_cycles);
        int waited;
        waited = 0;
        idle_cycles(1);
        while (tracker.expected_results.size() != 0 && waited < max_cycles) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (6) @(posedge i_clk);
    endtask

    // one transfer, then the burst/gap pattern of the sender
    task automatic issue_item(input t_req it);
        start <= 1'b1;
        i_req <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (it.func == FUNC_ENQ) begin
            addr_pool.push_back(it.address);
            if (addr_pool.size() > 24) void'(addr_pool.pop_front());
        end
        burst_left--;
        if (burst_left <= 0) begin
            idle_cycles($urandom_range(1, 8));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end else if ($urandom_range(0, 99) == 0) begin
            drain_results(100000);
        end
    endtask

    // run-time limit
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        tracker    = new();
        burst_left = $urandom_range(1, 8);
        counted    = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue: cancel, empty reply, unused code -> nothing
        issue_item(make_item(FUNC_CANCEL, 8'h00, '0, '0, '0));
        issue_item(make_item(FUNC_REPLY, 8'hFF, '1, '1, '0));
        issue_item(make_item(t_func'(2'd3), 8'hFF, '1, '1, '1));
        // field extremes and a duplicated address
        issue_item(make_item(FUNC_ENQ, 8'h00, '0, '0, '1));
        issue_item(make_item(FUNC_ENQ, 8'hFF, '1, 12'd2048, '0));
        issue_item(make_item(FUNC_ENQ, 8'hA5, {16{4'h5}}, 12'd4095, 12'd1));
        issue_item(make_item(FUNC_ENQ, 8'h5A, {16{4'hA}}, 12'd100, 12'd2));
        issue_item(make_item(FUNC_ENQ, 8'h11, {16{4'hA}}, 12'd50, 12'd3));
        // oldest duplicate answered from the middle, shorter reply
        issue_item(make_item(FUNC_REPLY, 8'h00, {16{4'hA}}, '0, 12'd30));
        // longer reply clipped to the request
        issue_item(make_item(FUNC_REPLY, 8'h00, '1, '0, 12'd4095));
        // nonempty reply that matches nothing
        issue_item(make_item(FUNC_REPLY, 8'h00, 64'h1234, '0, 12'd7));
        // lengths above 2048 pass through
        issue_item(make_item(FUNC_REPLY, 8'h00, {16{4'h5}}, '0, 12'd2049));
        // empty reply that does match
        issue_item(make_item(FUNC_REPLY, 8'h00, '0, '0, '0));
        issue_item(make_item(FUNC_ENQ, 8'h21, 64'h100, 12'd16, '0));
        issue_item(make_item(FUNC_ENQ, 8'h22, 64'h200, 12'd32, '0));
        issue_item(make_item(FUNC_ENQ, 8'h23, 64'h300, 12'd64, '0));
        // empty reply without a match flushes everything
        issue_item(make_item(FUNC_REPLY, 8'h00, 64'h999, '0, '0));
        issue_item(make_item(FUNC_ENQ, 8'h31, 64'h400, 12'd8, '0));
        issue_item(make_item(FUNC_ENQ, 8'h32, 64'h500, 12'd9, '0));
        issue_item(make_item(FUNC_CANCEL, 8'h00, '0, '0, '0));
        drain_results(100000);

        // random traffic, with one fill past the full mark
        while (counted < 285) begin
            if (counted == 120) begin
                issue_item(make_item(FUNC_CANCEL, TAG_W'($urandom), rand_addr(),
                                     LEN_W'($urandom), LEN_W'($urandom)));
                repeat (DEFAULT_SLOTS + 2)
                    issue_item(make_item(FUNC_ENQ, TAG_W'($urandom), rand_addr(),
                                         rand_len(), LEN_W'($urandom)));
                counted += DEFAULT_SLOTS + 3;
            end
            item = next_random_item();
            issue_item(item);
            if (item.func <= FUNC_CANCEL) counted++;
        end

        drain_results(20000);
        tracker.flag_leftovers();
        if (tracker.failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/prmq_pkg.sv
hw/rtl/prmq_cell.sv
hw/rtl/prmq_pick.sv
hw/rtl/pending_read_match_queue_unit.sv
verif/pending_read_match_queue_unit_test.sv
